@@ hdl/sobel_pkg.sv @@
package sobel_pkg;

    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int PIX_W          = 8;
    localparam int COORD_W        = 10;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd1024;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd1024;
    localparam logic [CFG_W-1:0] RST_THRESH = 11'd0;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;

    // result slots of one input word, in emission order
    localparam int NSLOT = 4;
    localparam logic [1:0] SLOT_A = 2'd0;   // row above, previous column
    localparam logic [1:0] SLOT_B = 2'd1;   // row above, row end
    localparam logic [1:0] SLOT_C = 2'd2;   // last row, previous column
    localparam logic [1:0] SLOT_D = 2'd3;   // last row, row end

    localparam int GRAD_W   = 10;
    localparam int SQ_W     = 2 * GRAD_W;
    localparam int MAG_W    = SQ_W + 1;
    localparam int THR_SQ_W = 2 * CFG_W;

    localparam int QUEUE_DEPTH = 8;
    localparam int PIPE_SLACK  = 5;

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    typedef logic [8:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic valid;
        logic row_end;
        logic last_row;
        logic first_col;
        logic second_col;
        logic first_row;
        logic second_row;
    } t_ctl;

    typedef struct packed {
        logic [NSLOT-1:0] mask;
        logic [NSLOT-1:0] hit;
    } t_grp;

    typedef struct packed {
        logic [GRAD_W-1:0] ax;
        logic [GRAD_W-1:0] ay;
    } t_grad;

    function automatic logic [PIX_W-1:0] win_px(t_win w, logic [1:0] row, logic [1:0] col);
        logic [3:0] k;
        k = 4'({row, 1'b0}) + 4'(row) + 4'(col);
        return w[k];
    endfunction

    function automatic t_grad grad_at(t_win w, logic [1:0] t, logic [1:0] m, logic [1:0] b,
                                      logic [1:0] l, logic [1:0] ce, logic [1:0] rt);
        logic [10:0] s_b;
        logic [10:0] s_t;
        logic [10:0] s_r;
        logic [10:0] s_l;
        logic [10:0] dx;
        logic [10:0] dy;
        t_grad       g;
        s_b = 11'(win_px(w, b, l)) + {2'b0, win_px(w, b, ce), 1'b0} + 11'(win_px(w, b, rt));
        s_t = 11'(win_px(w, t, l)) + {2'b0, win_px(w, t, ce), 1'b0} + 11'(win_px(w, t, rt));
        s_r = 11'(win_px(w, t, rt)) + {2'b0, win_px(w, m, rt), 1'b0} + 11'(win_px(w, b, rt));
        s_l = 11'(win_px(w, t, l)) + {2'b0, win_px(w, m, l), 1'b0} + 11'(win_px(w, b, l));
        dx = (s_b >= s_t) ? s_b - s_t : s_t - s_b;
        dy = (s_r >= s_l) ? s_r - s_l : s_l - s_r;
        g.ax = dx[GRAD_W-1:0];
        g.ay = dy[GRAD_W-1:0];
        return g;
    endfunction

endpackage

@@ hdl/sobel_edge_threshold.sv @@
// Channel   Direction  Handshake                         Word
// pixel     in         i_pixel_valid / o_pixel_ready     i_pixel
// result    out        o_result_valid / i_result_ready   o_edge_value, o_out_col, o_out_row,
//                                                        o_run_last, o_frame_end
// config    in         i_cfg_we (no wait)                i_cfg_index, i_cfg_data
//
// One pixel word per cycle while o_pixel_ready is high.
// The result port moves one word per cycle while i_result_ready is high, so on the last row
// (up to four results per pixel) the pixel side is held off by the result queue filling.
// Line stores: one 1-port-write / 1-port-read RAM, read-modify-write with forwarding when
// the same column is read and written at one edge (narrow images).
// Reset is synchronous; no clearing pass, the line stores are valid once written.
module sobel_edge_threshold import sobel_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_pixel_valid,
    output logic                 o_pixel_ready,
    input  logic [PIX_W-1:0]     i_pixel,
    output logic                 o_result_valid,
    input  logic                 i_result_ready,
    output logic [PIX_W-1:0]     o_edge_value,
    output logic [COORD_W-1:0]   o_out_col,
    output logic [COORD_W-1:0]   o_out_row,
    output logic                 o_run_last,
    output logic                 o_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CFG_W-1:0]    r_width;
    logic [CFG_W-1:0]    r_height;
    logic [CFG_W-1:0]    r_thresh;
    logic [THR_SQ_W-1:0] r_thr_sq;

    logic                accept;
    t_win                win;
    t_ctl                ctl;
    logic [CW-1:0]       win_col;
    logic [RW-1:0]       win_row;
    logic                push;
    t_grp                grp;
    logic [CW-1:0]       grp_col;
    logic [RW-1:0]       grp_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_thresh <= RST_THRESH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                REG_THRESH: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr_sq <= THR_SQ_W'(r_thresh) * THR_SQ_W'(r_thresh);
    end

    assign accept = i_pixel_valid && o_pixel_ready;

    sobel_line_win #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_line_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pixel  (i_pixel),
        .i_width  (r_width),
        .i_height (r_height),
        .o_win    (win),
        .o_ctl    (ctl),
        .o_col    (win_col),
        .o_row    (win_row)
    );

    sobel_grad #(
        .CW (CW),
        .RW (RW)
    ) u_grad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_win    (win),
        .i_ctl    (ctl),
        .i_col    (win_col),
        .i_row    (win_row),
        .i_thr_sq (r_thr_sq),
        .o_push   (push),
        .o_grp    (grp),
        .o_col    (grp_col),
        .o_row    (grp_row)
    );

    sobel_out_q #(
        .CW (CW),
        .RW (RW)
    ) u_out_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_grp        (grp),
        .i_col        (grp_col),
        .i_row        (grp_row),
        .o_space      (o_pixel_ready),
        .o_valid      (o_result_valid),
        .i_ready      (i_result_ready),
        .o_edge_value (o_edge_value),
        .o_col        (o_out_col),
        .o_row        (o_out_row),
        .o_run_last   (o_run_last),
        .o_frame_end  (o_frame_end)
    );

endmodule

@@ hdl/sobel_ram.sv @@
module sobel_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/sobel_line_win.sv @@
module sobel_line_win import sobel_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic [CFG_W-1:0] i_width,
    input  logic [CFG_W-1:0] i_height,
    output t_win             o_win,
    output t_ctl             o_ctl,
    output logic [CW-1:0]    o_col,
    output logic [RW-1:0]    o_row
);

    localparam int SW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int HW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [SW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;
    logic               row_end;
    logic               last_row;
    t_ctl               n_ctl;

    t_ctl               r_s1_ctl;
    logic [PIX_W-1:0]   r_s1_pix;
    logic [CW-1:0]      r_s1_col;
    logic [RW-1:0]      r_s1_row;
    logic               r_s1_fwd;
    logic [PIX_W-1:0]   r_fwd_u;
    logic [PIX_W-1:0]   r_fwd_m;
    logic               collide;

    logic [2*PIX_W-1:0] rd_data;
    logic [PIX_W-1:0]   u_eff;
    logic [PIX_W-1:0]   m_eff;

    t_win               r_win;
    t_win               n_win;
    t_ctl               r_s2_ctl;
    logic [CW-1:0]      r_s2_col;
    logic [RW-1:0]      r_s2_row;

    always_comb begin
        if (i_width == '0) begin
            w_eff = SW'(1);
        end else if (SW'(i_width) > SW'(MAX_WIDTH)) begin
            w_eff = SW'(MAX_WIDTH);
        end else begin
            w_eff = SW'(i_width);
        end
        if (i_height == '0) begin
            h_eff = HW'(1);
        end else if (HW'(i_height) > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(i_height);
        end
    end

    assign row_end  = (SW'(r_col) + SW'(1)) >= w_eff;
    assign last_row = (HW'(r_row) + HW'(1)) >= h_eff;

    always_comb begin
        n_ctl.valid      = i_accept;
        n_ctl.row_end    = row_end;
        n_ctl.last_row   = last_row;
        n_ctl.first_col  = (r_col == '0);
        n_ctl.second_col = (r_col == CW'(1));
        n_ctl.first_row  = (r_row == '0);
        n_ctl.second_row = (r_row == RW'(1));
    end

    // read of the entry that the word in the next stage writes at this edge
    assign collide = r_s1_ctl.valid && (r_s1_col == r_col);

    sobel_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (r_s1_ctl.valid),
        .i_waddr (r_s1_col),
        .i_wdata ({m_eff, r_s1_pix}),
        .i_re    (i_accept),
        .i_raddr (r_col),
        .o_rdata (rd_data)
    );

    assign u_eff = r_s1_fwd ? r_fwd_u : rd_data[2*PIX_W-1:PIX_W];
    assign m_eff = r_s1_fwd ? r_fwd_m : rd_data[PIX_W-1:0];

    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = u_eff;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = m_eff;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_win    <= '0;
        end else begin
            if (i_accept) begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            r_s1_ctl <= n_ctl;
            r_s2_ctl <= r_s1_ctl;
            if (r_s1_ctl.valid) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pix <= i_pixel;
        r_s1_col <= r_col;
        r_s1_row <= r_row;
        r_s1_fwd <= collide;
        r_fwd_u  <= m_eff;
        r_fwd_m  <= r_s1_pix;
        r_s2_col <= r_s1_col;
        r_s2_row <= r_s1_row;
    end

    assign o_win = r_win;
    assign o_ctl = r_s2_ctl;
    assign o_col = r_s2_col;
    assign o_row = r_s2_row;

endmodule

@@ hdl/sobel_grad.sv @@
module sobel_grad import sobel_pkg::*; #(
    parameter int CW = 10,
    parameter int RW = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_win                i_win,
    input  t_ctl                i_ctl,
    input  logic [CW-1:0]       i_col,
    input  logic [RW-1:0]       i_row,
    input  logic [THR_SQ_W-1:0] i_thr_sq,
    output logic                o_push,
    output t_grp                o_grp,
    output logic [CW-1:0]       o_col,
    output logic [RW-1:0]       o_row
);

    logic [NSLOT-1:0] mask;
    logic [1:0]       top1;
    logic [1:0]       top2;
    logic [1:0]       lc;
    logic [1:0]       lce;
    t_grad            grad [NSLOT];

    logic [NSLOT-1:0] r_mask3;
    t_grad            r_grad [NSLOT];
    logic [CW-1:0]    r_col3;
    logic [RW-1:0]    r_row3;

    logic [SQ_W-1:0]  sqx [NSLOT];
    logic [SQ_W-1:0]  sqy [NSLOT];

    logic [NSLOT-1:0] r_mask4;
    logic [MAG_W-1:0] r_mag [NSLOT];
    logic [CW-1:0]    r_col4;
    logic [RW-1:0]    r_row4;

    always_comb begin
        mask[SLOT_A] = i_ctl.valid && !i_ctl.first_row && !i_ctl.first_col;
        mask[SLOT_B] = i_ctl.valid && !i_ctl.first_row && i_ctl.row_end;
        mask[SLOT_C] = i_ctl.valid && i_ctl.last_row && !i_ctl.first_col;
        mask[SLOT_D] = i_ctl.valid && i_ctl.last_row && i_ctl.row_end;
        top1 = i_ctl.second_row ? 2'd1 : 2'd0;
        top2 = i_ctl.first_row ? 2'd2 : 2'd1;
        lc   = i_ctl.second_col ? 2'd1 : 2'd0;
        lce  = i_ctl.first_col ? 2'd2 : 2'd1;
        grad[SLOT_A] = grad_at(i_win, top1, 2'd1, 2'd2, lc, 2'd1, 2'd2);
        grad[SLOT_B] = grad_at(i_win, top1, 2'd1, 2'd2, lce, 2'd2, 2'd2);
        grad[SLOT_C] = grad_at(i_win, top2, 2'd2, 2'd2, lc, 2'd1, 2'd2);
        grad[SLOT_D] = grad_at(i_win, top2, 2'd2, 2'd2, lce, 2'd2, 2'd2);
    end

    always_comb begin
        for (int i = 0; i < NSLOT; i++) begin
            sqx[i] = SQ_W'(r_grad[i].ax) * SQ_W'(r_grad[i].ax);
            sqy[i] = SQ_W'(r_grad[i].ay) * SQ_W'(r_grad[i].ay);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask3 <= '0;
            r_mask4 <= '0;
        end else begin
            r_mask3 <= mask;
            r_mask4 <= r_mask3;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NSLOT; i++) begin
            r_grad[i] <= grad[i];
            r_mag[i]  <= {1'b0, sqx[i]} + {1'b0, sqy[i]};
        end
        r_col3 <= i_col;
        r_row3 <= i_row;
        r_col4 <= r_col3;
        r_row4 <= r_row3;
    end

    always_comb begin
        o_grp.mask = r_mask4;
        for (int i = 0; i < NSLOT; i++) begin
            o_grp.hit[i] = {1'b0, r_mag[i]} >= i_thr_sq;
        end
    end

    assign o_push = |r_mask4;
    assign o_col  = r_col4;
    assign o_row  = r_row4;

endmodule

@@ hdl/sobel_out_q.sv @@
module sobel_out_q import sobel_pkg::*; #(
    parameter int CW = 10,
    parameter int RW = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_grp               i_grp,
    input  logic [CW-1:0]      i_col,
    input  logic [RW-1:0]      i_row,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_edge_value,
    output logic [COORD_W-1:0] o_col,
    output logic [COORD_W-1:0] o_row,
    output logic               o_run_last,
    output logic               o_frame_end
);

    localparam int QAW  = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_grp               r_grp  [QUEUE_DEPTH];
    logic [CW-1:0]      r_qcol [QUEUE_DEPTH];
    logic [RW-1:0]      r_qrow [QUEUE_DEPTH];
    logic [QAW-1:0]     r_wr;
    logic [QAW-1:0]     r_rd;
    logic [CNTW-1:0]    r_cnt;
    logic [NSLOT-1:0]   r_sent;

    t_grp               head;
    logic [NSLOT-1:0]   remaining;
    logic [1:0]         slot;
    logic [NSLOT-1:0]   slot_bit;
    logic               last;
    logic               load;
    logic               pop;
    logic [CW-1:0]      col_sel;
    logic [RW-1:0]      row_sel;
    logic [31:0]        col_ext;
    logic [31:0]        row_ext;

    logic               r_valid;
    logic [PIX_W-1:0]   r_edge;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic               r_last;
    logic               r_fend;

    assign head      = r_grp[r_rd];
    assign remaining = head.mask & ~r_sent;

    always_comb begin
        if (remaining[SLOT_A]) begin
            slot = SLOT_A;
        end else if (remaining[SLOT_B]) begin
            slot = SLOT_B;
        end else if (remaining[SLOT_C]) begin
            slot = SLOT_C;
        end else begin
            slot = SLOT_D;
        end
    end

    assign slot_bit = NSLOT'(1) << slot;
    assign last     = (remaining & ~slot_bit) == '0;
    assign load     = (r_cnt != '0) && (!r_valid || i_ready);
    assign pop      = load && last;
    assign o_space  = r_cnt <= CNTW'(QUEUE_DEPTH - PIPE_SLACK);

    always_comb begin
        col_sel = r_qcol[r_rd];
        row_sel = r_qrow[r_rd];
        if (slot == SLOT_A || slot == SLOT_C) begin
            col_sel = r_qcol[r_rd] - CW'(1);
        end
        if (slot == SLOT_A || slot == SLOT_B) begin
            row_sel = r_qrow[r_rd] - RW'(1);
        end
        col_ext = 32'(col_sel);
        row_ext = 32'(row_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
            r_sent  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + CNTW'(1);
                2'b01:   r_cnt <= r_cnt - CNTW'(1);
                default: r_cnt <= r_cnt;
            endcase
            if (load) begin
                r_valid <= 1'b1;
                r_sent  <= last ? '0 : (r_sent | slot_bit);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_grp[r_wr]  <= i_grp;
            r_qcol[r_wr] <= i_col;
            r_qrow[r_wr] <= i_row;
        end
        if (load) begin
            r_edge <= head.hit[slot] ? EDGE_ON : EDGE_OFF;
            r_col  <= col_ext[COORD_W-1:0];
            r_row  <= row_ext[COORD_W-1:0];
            r_last <= last;
            r_fend <= (slot == SLOT_D);
        end
    end

    assign o_valid      = r_valid;
    assign o_edge_value = r_edge;
    assign o_col        = r_col;
    assign o_row        = r_row;
    assign o_run_last   = r_last;
    assign o_frame_end  = r_fend;

endmodule
